// File: sv/irpd_pkg.sv
// Shared types, constants and tables of the IQ residual phase drift check.
package irpd_pkg;

  localparam int WINDOW_SAMPLES = 32;
  localparam int MAX_BLOCK      = 4096;
  localparam int SAMPLE_BITS    = 12;
  localparam int IDX_W          = 13;
  localparam int ANG_W          = 24;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CORDIC_STEPS   = 23;

  localparam logic [1:0] CFG_ADC_MIDPOINT = 2'd0;
  localparam logic [1:0] CFG_PHASE_STEP   = 2'd1;
  localparam logic [1:0] CFG_END_PHASE    = 2'd2;
  localparam logic [1:0] CFG_BLOCK_LENGTH = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] ci;
    logic signed [SAMPLE_BITS:0] cq;
    logic [ANG_W-1:0]            phase;
    logic                        in_head;
    logic                        in_tail;
    logic                        last;
    logic                        len_ok;
  } irpd_entry_t;

  typedef struct packed {
    logic        verify_valid;
    logic [22:0] raw_drift;
    logic [22:0] rot_drift;
    logic [16:0] head_raw_mag;
    logic [16:0] tail_raw_mag;
    logic [16:0] head_rot_mag;
    logic [16:0] tail_rot_mag;
    logic [31:0] improvement;
  } irpd_result_t;

  typedef enum logic [4:0] {
    B_IDLE, B_ROT, B_MUL1, B_MUL2, B_ACC, B_FIN, B_VLD, B_VEC, B_SQ1, B_SQ2,
    B_SQRT, B_U1, B_U2, B_U3, B_DV0, B_DIV, B_DONE
  } irpd_state_t;

  // Arctangent of 2^-k in units of pi/2^23 rad.
  function automatic logic [22:0] atan_at(input logic [4:0] k);
    logic [22:0] a;
    case (k)
      5'd0:  a = 23'd2097152;
      5'd1:  a = 23'd1238021;
      5'd2:  a = 23'd654136;
      5'd3:  a = 23'd332050;
      5'd4:  a = 23'd166669;
      5'd5:  a = 23'd83416;
      5'd6:  a = 23'd41718;
      5'd7:  a = 23'd20860;
      5'd8:  a = 23'd10430;
      5'd9:  a = 23'd5215;
      5'd10: a = 23'd2608;
      5'd11: a = 23'd1304;
      5'd12: a = 23'd652;
      5'd13: a = 23'd326;
      5'd14: a = 23'd163;
      5'd15: a = 23'd81;
      5'd16: a = 23'd41;
      5'd17: a = 23'd20;
      5'd18: a = 23'd10;
      5'd19: a = 23'd5;
      5'd20: a = 23'd3;
      5'd21: a = 23'd1;
      5'd22: a = 23'd1;
      default: a = 23'd0;
    endcase
    return a;
  endfunction

endpackage

// File: sv/irpd_front.sv
// Front end: configuration registers, block position, phase accumulator and window marking.
module irpd_front #(
  parameter int WINDOW_SAMPLES = irpd_pkg::WINDOW_SAMPLES,
  parameter int MAX_BLOCK      = irpd_pkg::MAX_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [23:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           i_sample,
  input  logic [11:0]           q_sample,
  output logic                  push_valid,
  input  logic                  push_ready,
  output irpd_pkg::irpd_entry_t push_data
);

  logic [11:0] mid_r;
  logic [23:0] step_r;
  logic [23:0] endp_r;
  logic [12:0] blen_r;
  logic [12:0] idx_r;
  logic [23:0] rot_r;

  logic [12:0] len;
  logic [12:0] tail_start;
  logic        in_head;
  logic        in_tail;
  logic        last;
  logic [36:0] start_prod;
  logic [23:0] phase;

  always_comb begin
    len        = (32'(blen_r) > MAX_BLOCK) ? 13'(MAX_BLOCK) : blen_r;
    tail_start = (32'(len) > WINDOW_SAMPLES) ? len - 13'(WINDOW_SAMPLES) : 13'd0;
    in_head    = 32'(idx_r) < WINDOW_SAMPLES;
    in_tail    = idx_r >= tail_start;
    last       = ({1'b0, idx_r} + 14'd1) >= {1'b0, len};
    start_prod = 37'(step_r) * 37'(len);
    // The first word of a block sets the start angle back from the end phase.
    phase      = (idx_r == 13'd0) ? endp_r - start_prod[23:0] : rot_r;

    push_data.ci      = $signed({1'b0, i_sample}) - $signed({1'b0, mid_r});
    push_data.cq      = $signed({1'b0, q_sample}) - $signed({1'b0, mid_r});
    push_data.phase   = phase;
    push_data.in_head = in_head;
    push_data.in_tail = in_tail;
    push_data.last    = last;
    push_data.len_ok  = 32'(len) >= 2 * WINDOW_SAMPLES;

    in_ready   = push_ready;
    push_valid = in_valid & (in_head | in_tail | last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r  <= 12'd2048;
      step_r <= '0;
      endp_r <= '0;
      blen_r <= 13'd1024;
      idx_r  <= '0;
      rot_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          irpd_pkg::CFG_ADC_MIDPOINT: mid_r  <= cfg_wdata[11:0];
          irpd_pkg::CFG_PHASE_STEP:   step_r <= cfg_wdata;
          irpd_pkg::CFG_END_PHASE:    endp_r <= cfg_wdata;
          irpd_pkg::CFG_BLOCK_LENGTH: blen_r <= cfg_wdata[12:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        idx_r <= last ? 13'd0 : idx_r + 13'd1;
        rot_r <= phase + step_r;
      end
    end
  end

endmodule

// File: sv/irpd_queue.sv
// Short queue of marked samples between the front and back ends.
module irpd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  irpd_pkg::irpd_entry_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output irpd_pkg::irpd_entry_t pop_data
);

  localparam int PW = $clog2(irpd_pkg::QUEUE_DEPTH);

  irpd_pkg::irpd_entry_t mem_r [irpd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = cnt_r != (PW+1)'(irpd_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + PW'(1);
      if (do_pop)  rp_r <= rp_r + PW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

// File: sv/irpd_back.sv
// Back end: derotation CORDIC, window sums, and the per-block angle, norm and drift sequencer.
module irpd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  irpd_pkg::irpd_entry_t  pop_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output irpd_pkg::irpd_result_t out_data
);

  localparam logic signed [25:0] QT = 26'sd4194304;
  localparam logic signed [25:0] HT = 26'sd8388608;
  localparam logic signed [32:0] GAIN = 33'sd652032874;
  localparam int SAMPLE_W = irpd_pkg::SAMPLE_BITS;

  irpd_pkg::irpd_state_t state_r, state_nxt;
  irpd_pkg::irpd_entry_t ent_r, ent_nxt;
  logic [4:0] k_r, k_nxt;
  logic signed [32:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [25:0] cz_r, cz_nxt;
  logic flip_r, flip_nxt;
  logic signed [45:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic signed [24:0] ri_r, ri_nxt;
  logic signed [17:0] rhi_r, rhi_nxt, rhq_r, rhq_nxt, rti_r, rti_nxt, rtq_r, rtq_nxt;
  logic signed [31:0] dhi_r, dhi_nxt, dhq_r, dhq_nxt, dti_r, dti_nxt, dtq_r, dtq_nxt;
  logic [1:0] vidx_r, vidx_nxt;
  logic signed [59:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [25:0] vz_r, vz_nxt;
  logic [23:0] ang_r [4];
  logic [23:0] ang_nxt [4];
  logic [16:0] mag_r [4];
  logic [16:0] mag_nxt [4];
  logic [63:0] sq_r, sq_nxt, rad_r, rad_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic usel_r, usel_nxt, dneg_r, dneg_nxt;
  logic [55:0] um_r, um_nxt;
  logic [64:0] uq_r, uq_nxt;
  logic signed [22:0] ru_r, ru_nxt, du_r, du_nxt;
  logic [21:0] ra_r, ra_nxt;
  logic nneg_r, nneg_nxt;
  logic [31:0] dd_r, dd_nxt, dq_r, dq_nxt, imp_r, imp_nxt;
  logic [22:0] dr_r, dr_nxt;
  logic rvalid_r, rvalid_nxt;
  logic ovalid_r, ovalid_nxt;
  irpd_pkg::irpd_result_t res_r, res_nxt;

  // Scratch values of the combinational step.
  logic signed [SAMPLE_W:0] eci, ecq;
  logic signed [25:0] zs, atan_s;
  logic signed [32:0] c, s;
  logic signed [46:0] sa;
  logic signed [31:0] vi, vq;
  logic signed [63:0] sqv;
  logic [63:0] tsum, rfin, r8;
  logic [23:0] dsel, dmag;
  logic [22:0] qv, raa, daa;
  logic signed [22:0] diff_s;
  logic signed [33:0] nn, nabs;
  logic [22:0] sh;
  logic [31:0] qf;
  logic nz_ok;

  always_comb begin
    eci    = ent_r.ci;
    ecq    = ent_r.cq;
    atan_s = $signed({3'b000, irpd_pkg::atan_at(k_r)});
    c      = flip_r ? -cx_r : cx_r;
    s      = flip_r ? -cy_r : cy_r;
    case (vidx_r)
      2'd0:    begin vi = 32'(rhi_r); vq = 32'(rhq_r); end
      2'd1:    begin vi = 32'(rti_r); vq = 32'(rtq_r); end
      2'd2:    begin vi = dhi_r; vq = dhq_r; end
      default: begin vi = dti_r; vq = dtq_r; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;  ent_nxt = ent_r;   k_nxt = k_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;  flip_nxt = flip_r;
    pa_nxt = pa_r;  pb_nxt = pb_r;  ri_nxt = ri_r;
    rhi_nxt = rhi_r; rhq_nxt = rhq_r; rti_nxt = rti_r; rtq_nxt = rtq_r;
    dhi_nxt = dhi_r; dhq_nxt = dhq_r; dti_nxt = dti_r; dtq_nxt = dtq_r;
    vidx_nxt = vidx_r; vx_nxt = vx_r; vy_nxt = vy_r; vz_nxt = vz_r;
    ang_nxt = ang_r;  mag_nxt = mag_r;
    sq_nxt = sq_r; rad_nxt = rad_r; root_nxt = root_r; bit_nxt = bit_r;
    usel_nxt = usel_r; dneg_nxt = dneg_r; um_nxt = um_r; uq_nxt = uq_r;
    ru_nxt = ru_r; du_nxt = du_r; ra_nxt = ra_r; nneg_nxt = nneg_r;
    dd_nxt = dd_r; dq_nxt = dq_r; dr_nxt = dr_r; imp_nxt = imp_r;
    rvalid_nxt = rvalid_r; res_nxt = res_r;
    ovalid_nxt = ovalid_r & ~out_ready;
    pop_ready = 1'b0;
    zs = '0; sa = '0; sqv = '0; tsum = '0; rfin = '0; r8 = '0;
    dsel = '0; dmag = '0; qv = '0; raa = '0; daa = '0; diff_s = '0;
    nn = '0; nabs = '0; sh = '0; qf = '0;
    nz_ok = 1'b0;

    case (state_r)
      irpd_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          ent_nxt = pop_data;
          if (pop_data.in_head) begin
            rhi_nxt = rhi_r + 18'(pop_data.ci);
            rhq_nxt = rhq_r + 18'(pop_data.cq);
          end
          if (pop_data.in_tail) begin
            rti_nxt = rti_r + 18'(pop_data.ci);
            rtq_nxt = rtq_r + 18'(pop_data.cq);
          end
          // Fold the angle into the right half plane; the result is negated afterwards.
          zs = 26'($signed(pop_data.phase));
          flip_nxt = 1'b0;
          if (zs > QT) begin
            zs = zs - HT;  flip_nxt = 1'b1;
          end else if (zs < -QT) begin
            zs = zs + HT;  flip_nxt = 1'b1;
          end
          cz_nxt = zs;  cx_nxt = GAIN;  cy_nxt = '0;  k_nxt = '0;
          if (pop_data.in_head || pop_data.in_tail) state_nxt = irpd_pkg::B_ROT;
          else if (pop_data.last)                   state_nxt = irpd_pkg::B_FIN;
        end
      end
      irpd_pkg::B_ROT: begin
        if (!cz_r[25]) begin
          cx_nxt = cx_r - (cy_r >>> k_r);  cy_nxt = cy_r + (cx_r >>> k_r);
          cz_nxt = cz_r - atan_s;
        end else begin
          cx_nxt = cx_r + (cy_r >>> k_r);  cy_nxt = cy_r - (cx_r >>> k_r);
          cz_nxt = cz_r + atan_s;
        end
        k_nxt = k_r + 5'd1;
        if (k_r == 5'(irpd_pkg::CORDIC_STEPS - 1)) state_nxt = irpd_pkg::B_MUL1;
      end
      irpd_pkg::B_MUL1: begin
        pa_nxt = c * eci;  pb_nxt = s * ecq;
        state_nxt = irpd_pkg::B_MUL2;
      end
      irpd_pkg::B_MUL2: begin
        sa = {pa_r[45], pa_r} + {pb_r[45], pb_r} + 47'sd2097152;
        ri_nxt = sa[46:22];
        pa_nxt = c * ecq;  pb_nxt = s * eci;
        state_nxt = irpd_pkg::B_ACC;
      end
      irpd_pkg::B_ACC: begin
        sa = {pa_r[45], pa_r} - {pb_r[45], pb_r} + 47'sd2097152;
        if (ent_r.in_head) begin
          dhi_nxt = dhi_r + 32'(ri_r);  dhq_nxt = dhq_r + 32'($signed(sa[46:22]));
        end
        if (ent_r.in_tail) begin
          dti_nxt = dti_r + 32'(ri_r);  dtq_nxt = dtq_r + 32'($signed(sa[46:22]));
        end
        state_nxt = ent_r.last ? irpd_pkg::B_FIN : irpd_pkg::B_IDLE;
      end
      irpd_pkg::B_FIN: begin
        nz_ok = ((rhi_r != '0) || (rhq_r != '0)) && ((rti_r != '0) || (rtq_r != '0)) &&
                ((dhi_r != '0) || (dhq_r != '0)) && ((dti_r != '0) || (dtq_r != '0));
        rvalid_nxt = ent_r.len_ok & nz_ok;
        vidx_nxt = '0;
        usel_nxt = 1'b0;
        state_nxt = (ent_r.len_ok && nz_ok) ? irpd_pkg::B_VLD : irpd_pkg::B_DONE;
      end
      irpd_pkg::B_VLD: begin
        vx_nxt = {{4{vi[31]}}, vi, 24'd0};
        vy_nxt = {{4{vq[31]}}, vq, 24'd0};
        vz_nxt = '0;
        if (vi[31]) begin
          vx_nxt = -vx_nxt;  vy_nxt = -vy_nxt;  vz_nxt = HT;
        end
        k_nxt = '0;
        state_nxt = irpd_pkg::B_VEC;
      end
      irpd_pkg::B_VEC: begin
        if (vy_r > 60'sd0) begin
          vx_nxt = vx_r + (vy_r >>> k_r);  vy_nxt = vy_r - (vx_r >>> k_r);
          vz_nxt = vz_r + atan_s;
        end else begin
          vx_nxt = vx_r - (vy_r >>> k_r);  vy_nxt = vy_r + (vx_r >>> k_r);
          vz_nxt = vz_r - atan_s;
        end
        k_nxt = k_r + 5'd1;
        if (k_r == 5'(irpd_pkg::CORDIC_STEPS - 1)) begin
          ang_nxt[vidx_r] = vz_nxt[23:0];
          state_nxt = irpd_pkg::B_SQ1;
        end
      end
      irpd_pkg::B_SQ1: begin
        sqv = vi * vi;
        sq_nxt = sqv;
        state_nxt = irpd_pkg::B_SQ2;
      end
      irpd_pkg::B_SQ2: begin
        sqv = vq * vq;
        rad_nxt = sq_r + sqv;
        root_nxt = '0;
        bit_nxt = 64'h4000_0000_0000_0000;
        k_nxt = '0;
        state_nxt = irpd_pkg::B_SQRT;
      end
      irpd_pkg::B_SQRT: begin
        tsum = root_r + bit_r;
        if (rad_r >= tsum) begin
          rad_nxt = rad_r - tsum;  root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        k_nxt = k_r + 5'd1;
        if (k_r == 5'd31) begin
          rfin = root_nxt;
          r8 = (rfin + 64'd128) >> 8;
          if (!vidx_r[1]) mag_nxt[vidx_r] = (rfin > 64'd131071) ? 17'h1FFFF : rfin[16:0];
          else            mag_nxt[vidx_r] = (r8 > 64'd131071) ? 17'h1FFFF : r8[16:0];
          vidx_nxt = vidx_r + 2'd1;
          state_nxt = (vidx_r == 2'd3) ? irpd_pkg::B_U1 : irpd_pkg::B_VLD;
        end
      end
      irpd_pkg::B_U1: begin
        dsel = usel_r ? ang_r[3] - ang_r[2] : ang_r[1] - ang_r[0];
        dneg_nxt = dsel[23];
        dmag = dsel[23] ? -dsel : dsel;
        um_nxt = 56'(dmag) * 56'd3141592654;
        state_nxt = irpd_pkg::B_U2;
      end
      irpd_pkg::B_U2: begin
        // Divide by 1000 through a reciprocal; exact for every product here.
        uq_nxt = 65'(um_r[54:23]) * 65'd4398046512;
        state_nxt = irpd_pkg::B_U3;
      end
      irpd_pkg::B_U3: begin
        qv = uq_r[64:42];
        if (usel_r) du_nxt = dneg_r ? -$signed(qv) : $signed(qv);
        else        ru_nxt = dneg_r ? -$signed(qv) : $signed(qv);
        usel_nxt = 1'b1;
        state_nxt = usel_r ? irpd_pkg::B_DV0 : irpd_pkg::B_U1;
      end
      irpd_pkg::B_DV0: begin
        raa = ru_r[22] ? 23'(-ru_r) : 23'(ru_r);
        daa = du_r[22] ? 23'(-du_r) : 23'(du_r);
        diff_s = $signed(raa) - $signed(daa);
        nn = diff_s * 34'sd1000;
        nneg_nxt = nn[33];
        nabs = nn[33] ? -nn : nn;
        dd_nxt = nabs[31:0];
        ra_nxt = raa[21:0];
        dq_nxt = '0;  dr_nxt = '0;  k_nxt = '0;
        imp_nxt = '0;
        state_nxt = (raa == '0) ? irpd_pkg::B_DONE : irpd_pkg::B_DIV;
      end
      irpd_pkg::B_DIV: begin
        sh = {dr_r[21:0], dd_r[31]};
        dd_nxt = {dd_r[30:0], 1'b0};
        if (sh >= {1'b0, ra_r}) begin
          dr_nxt = sh - {1'b0, ra_r};  dq_nxt = {dq_r[30:0], 1'b1};
        end else begin
          dr_nxt = sh;  dq_nxt = {dq_r[30:0], 1'b0};
        end
        k_nxt = k_r + 5'd1;
        if (k_r == 5'd31) begin
          qf = dq_nxt;
          if (nneg_r) imp_nxt = (qf > 32'h8000_0000) ? 32'h8000_0000 : -qf;
          else        imp_nxt = qf;
          state_nxt = irpd_pkg::B_DONE;
        end
      end
      irpd_pkg::B_DONE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          res_nxt = '0;
          if (rvalid_r) begin
            res_nxt.verify_valid = 1'b1;
            res_nxt.raw_drift    = ru_r;
            res_nxt.rot_drift    = du_r;
            res_nxt.head_raw_mag = mag_r[0];
            res_nxt.tail_raw_mag = mag_r[1];
            res_nxt.head_rot_mag = mag_r[2];
            res_nxt.tail_rot_mag = mag_r[3];
            res_nxt.improvement  = imp_r;
          end
          rhi_nxt = '0; rhq_nxt = '0; rti_nxt = '0; rtq_nxt = '0;
          dhi_nxt = '0; dhq_nxt = '0; dti_nxt = '0; dtq_nxt = '0;
          state_nxt = irpd_pkg::B_IDLE;
        end
      end
      default: state_nxt = irpd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irpd_pkg::B_IDLE;
      ovalid_r <= 1'b0;
      rhi_r <= '0; rhq_r <= '0; rti_r <= '0; rtq_r <= '0;
      dhi_r <= '0; dhq_r <= '0; dti_r <= '0; dtq_r <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      rhi_r <= rhi_nxt; rhq_r <= rhq_nxt; rti_r <= rti_nxt; rtq_r <= rtq_nxt;
      dhi_r <= dhi_nxt; dhq_r <= dhq_nxt; dti_r <= dti_nxt; dtq_r <= dtq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;  k_r <= k_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;  flip_r <= flip_nxt;
    pa_r <= pa_nxt;  pb_r <= pb_nxt;  ri_r <= ri_nxt;
    vidx_r <= vidx_nxt;  vx_r <= vx_nxt;  vy_r <= vy_nxt;  vz_r <= vz_nxt;
    ang_r <= ang_nxt;  mag_r <= mag_nxt;
    sq_r <= sq_nxt;  rad_r <= rad_nxt;  root_r <= root_nxt;  bit_r <= bit_nxt;
    usel_r <= usel_nxt;  dneg_r <= dneg_nxt;  um_r <= um_nxt;  uq_r <= uq_nxt;
    ru_r <= ru_nxt;  du_r <= du_nxt;  ra_r <= ra_nxt;  nneg_r <= nneg_nxt;
    dd_r <= dd_nxt;  dq_r <= dq_nxt;  dr_r <= dr_nxt;  imp_r <= imp_nxt;
    rvalid_r <= rvalid_nxt;  res_r <= res_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = res_r;

endmodule

// File: sv/iq_residual_phase_drift_check_unit.sv
// Top level of the IQ residual phase drift check.
// Usage:
//   The in_ channel takes one IQ sample pair per word. The user must write the
//   midpoint, phase step, end phase and block length on the cfg_ port only while
//   the block is idle; the block itself has no check for this. After the last
//   word of a block, one result word leaves on the out_ channel; out_tuser[0]
//   flags a valid check, otherwise all result fields are zero.
// Processing:
//   A window sample takes the back end through 23 derotation CORDIC iterations,
//   two multiply steps and an accumulate; a four-word queue lets the front run ahead.
//   For a valid check the block end runs four vectoring CORDIC passes of 23
//   steps, four 32-step square roots, two drift conversions and, unless the raw
//   drift is zero, a 32-step divider, all on one sequencer.
// Reset clears the block position, phase, window sums and output valid, and
//   loads the register defaults. A stalled receiver holds the result word in its
//   output register; the back end keeps working on the next block until it has
//   a new result of its own.
module iq_residual_phase_drift_check_unit #(
  parameter int WINDOW_SAMPLES = irpd_pkg::WINDOW_SAMPLES,
  parameter int MAX_BLOCK      = irpd_pkg::MAX_BLOCK
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [23:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // i_sample, q_sample
  output logic         out_tvalid,
  input  logic         out_tready,
  // raw_phase_drift_urad, derotated_phase_drift_urad, raw_head_magnitude,
  // raw_tail_magnitude, rot_head_magnitude, rot_tail_magnitude,
  // improvement_permille, zero fill
  output logic [151:0] out_tdata,
  output logic [0:0]   out_tuser   // verify_valid
);

  logic                   push_valid;
  logic                   push_ready;
  irpd_pkg::irpd_entry_t  push_data;
  logic                   pop_valid;
  logic                   pop_ready;
  irpd_pkg::irpd_entry_t  pop_data;
  irpd_pkg::irpd_result_t res;

  irpd_front #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES),
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .i_sample(in_tdata[11:0]), .q_sample(in_tdata[23:12]),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  irpd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  irpd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(res)
  );

  assign out_tuser[0] = res.verify_valid;
  assign out_tdata = {6'd0, res.improvement, res.tail_rot_mag, res.head_rot_mag,
                      res.tail_raw_mag, res.head_raw_mag, res.rot_drift, res.raw_drift};

endmodule

// File: sv/irpd_checker.sv
// Port-level checks of the IQ residual phase drift check, bound to the top level.
module irpd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata,
  input logic [0:0]   out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 152'd0)
    else $error("invalid result carries nonzero fields");

  a_imp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> $signed(out_tdata[145:114]) <= 32'sd1000)
    else $error("improvement above one thousand per mille");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind iq_residual_phase_drift_check_unit irpd_checker u_irpd_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
